>>> hdl/clex_pkg.sv
`timescale 1ns / 1ps
// Shared types, token codes and byte classification for the C subset lexer.
package clex_pkg;

	// Default width of the literal accumulator
	localparam int VALUE_WIDTH_DEF = 32;

	// Result field widths
	localparam int KIND_W  = 5;
	localparam int VALUE_W = 32;
	localparam int LINE_W  = 32;

	// Depth of the result queue
	localparam int RES_DEPTH = 4;

	// Token kinds
	localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
	localparam logic [KIND_W-1:0] K_NUM     = 5'd1;
	localparam logic [KIND_W-1:0] K_ID      = 5'd2;
	localparam logic [KIND_W-1:0] K_INT     = 5'd3;
	localparam logic [KIND_W-1:0] K_RET     = 5'd4;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd5;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd6;
	localparam logic [KIND_W-1:0] K_LBRACE  = 5'd7;
	localparam logic [KIND_W-1:0] K_RBRACE  = 5'd8;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd9;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd10;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd11;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd12;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd13;
	localparam logic [KIND_W-1:0] K_PERCENT = 5'd14;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd15;
	localparam logic [KIND_W-1:0] K_COMMA   = 5'd16;
	localparam logic [KIND_W-1:0] K_INVALID = 5'd17;
	localparam logic [KIND_W-1:0] K_BADHEX  = 5'd18;

	// One result token
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               overflow;
		logic [LINE_W-1:0]  line;
		logic               last;
	} tok_t;

	// Tokens produced by one byte, packed from slot 0
	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} lex_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= "0") && (c <= "7");
	endfunction

	function automatic logic is_alpha_us(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	// Digit value of a hex character; letters share the low nibble pattern
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] r;
		if (is_digit(c)) begin
			r = c[3:0];
		end else begin
			r = 4'(c[3:0] + 4'd9);
		end
		return r;
	endfunction

	// Map a punctuator byte to its kind, anything else is invalid
	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			";":     k = K_SEMI;
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			"/":     k = K_SLASH;
			"%":     k = K_PERCENT;
			"=":     k = K_ASSIGN;
			",":     k = K_COMMA;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] int_char(input logic [2:0] n);
		logic [7:0] r;
		unique case (n)
			3'd0:    r = "i";
			3'd1:    r = "n";
			3'd2:    r = "t";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ret_char(input logic [2:0] n);
		logic [7:0] r;
		unique case (n)
			3'd0:    r = "r";
			3'd1:    r = "e";
			3'd2:    r = "t";
			3'd3:    r = "u";
			3'd4:    r = "r";
			3'd5:    r = "n";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// Drop keyword candidates that the next identifier character rules out
	function automatic logic [1:0] kw_push(input logic [1:0] kw, input logic [2:0] n,
		input logic [7:0] c);
		logic [1:0] r;
		r = kw;
		if ((n >= 3'd3) || (int_char(n) != c)) begin
			r[0] = 1'b0;
		end
		if ((n >= 3'd6) || (ret_char(n) != c)) begin
			r[1] = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> hdl/clex_scan.sv
`timescale 1ns / 1ps
// Lexer state registers and per-byte token logic.
module clex_scan #(
	parameter int VALUE_WIDTH = clex_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          ch,
	input  logic                at_end,
	output clex_pkg::lex_res_t  res
);
	import clex_pkg::*;

	// Scan modes
	localparam logic [2:0] M_IDLE   = 3'd0;
	localparam logic [2:0] M_ZERO   = 3'd1;
	localparam logic [2:0] M_OCT    = 3'd2;
	localparam logic [2:0] M_DEC    = 3'd3;
	localparam logic [2:0] M_HEXPRE = 3'd4;
	localparam logic [2:0] M_HEX    = 3'd5;
	localparam logic [2:0] M_IDENT  = 3'd6;

	localparam int SUM_W = VALUE_WIDTH + 4;

	logic [2:0]             mode_q, mode_n;
	logic [VALUE_WIDTH-1:0] accum_q, accum_n;
	logic                   ovf_q, ovf_n;
	logic [1:0]             kw_q, kw_n;
	logic [2:0]             ilen_q, ilen_n;
	logic [LINE_W-1:0]      line_q, line_n, line_inc;
	logic                   cr_q, cr_n;

	logic [SUM_W-1:0]       acc_ext, acc_mul, acc_sum;
	logic [3:0]             acc_dig;
	logic [VALUE_WIDTH-1:0] acc_val;
	logic                   acc_ovf;

	tok_t                   tok_a, tok_b;
	logic                   a_v, b_v;
	logic [KIND_W-1:0]      b_kind, fl_kind;
	logic [VALUE_W-1:0]     b_val;
	logic                   ext;

	// Multiply-add of the literal: base picked by mode, saturate on carry-out
	assign acc_ext = SUM_W'(accum_q);
	assign acc_dig = ((mode_q == M_HEXPRE) || (mode_q == M_HEX)) ? hex_val(ch) : ch[3:0];
	always_comb begin
		if (mode_q == M_DEC) begin
			acc_mul = (acc_ext << 3) + (acc_ext << 1);
		end else if ((mode_q == M_HEXPRE) || (mode_q == M_HEX)) begin
			acc_mul = acc_ext << 4;
		end else begin
			acc_mul = acc_ext << 3;
		end
	end
	assign acc_sum = acc_mul + SUM_W'(acc_dig);
	assign acc_ovf = ovf_q || (|acc_sum[SUM_W-1:VALUE_WIDTH]);
	assign acc_val = acc_ovf ? {VALUE_WIDTH{1'b1}} : acc_sum[VALUE_WIDTH-1:0];

	// Saturating line increment
	assign line_inc = (line_q == {LINE_W{1'b1}}) ? line_q : line_q + LINE_W'(1);

	// Kind of the pending token when it is closed
	always_comb begin
		unique case (mode_q) inside
			M_ZERO, M_OCT, M_DEC, M_HEX: fl_kind = K_NUM;
			M_HEXPRE:                    fl_kind = K_BADHEX;
			M_IDENT: begin
				if (kw_q[0] && (ilen_q == 3'd3)) begin
					fl_kind = K_INT;
				end else if (kw_q[1] && (ilen_q == 3'd6)) begin
					fl_kind = K_RET;
				end else begin
					fl_kind = K_ID;
				end
			end
			default:                     fl_kind = K_EOF;
		endcase
	end

	assign tok_a.kind     = fl_kind;
	assign tok_a.value    = (fl_kind == K_NUM) ? VALUE_W'(accum_q) : '0;
	assign tok_a.overflow = (fl_kind == K_NUM) ? ovf_q : 1'b0;
	assign tok_a.line     = line_q;
	assign tok_a.last     = !b_v;

	assign tok_b.kind     = b_kind;
	assign tok_b.value    = b_val;
	assign tok_b.overflow = 1'b0;
	assign tok_b.line     = line_q;
	assign tok_b.last     = 1'b1;

	// Extend the pending token, or close it and handle the byte from idle
	always_comb begin
		mode_n  = mode_q;
		accum_n = accum_q;
		ovf_n   = ovf_q;
		kw_n    = kw_q;
		ilen_n  = ilen_q;
		line_n  = line_q;
		cr_n    = cr_q;
		a_v     = 1'b0;
		b_v     = 1'b0;
		b_kind  = K_EOF;
		b_val   = '0;
		ext     = 1'b0;
		if (at_end) begin
			a_v     = (mode_q != M_IDLE);
			b_v     = 1'b1;
			mode_n  = M_IDLE;
			accum_n = '0;
			ovf_n   = 1'b0;
			kw_n    = 2'b11;
			ilen_n  = 3'd0;
			line_n  = LINE_W'(1);
			cr_n    = 1'b0;
		end else begin
			unique case (mode_q) inside
				M_ZERO: begin
					if ((ch == "x") || (ch == "X")) begin
						ext    = 1'b1;
						mode_n = M_HEXPRE;
					end else if (is_oct(ch)) begin
						ext     = 1'b1;
						mode_n  = M_OCT;
						accum_n = acc_val;
						ovf_n   = acc_ovf;
					end
				end
				M_OCT: begin
					if (is_oct(ch)) begin
						ext     = 1'b1;
						accum_n = acc_val;
						ovf_n   = acc_ovf;
					end
				end
				M_DEC: begin
					if (is_digit(ch)) begin
						ext     = 1'b1;
						accum_n = acc_val;
						ovf_n   = acc_ovf;
					end
				end
				M_HEXPRE, M_HEX: begin
					if (is_hex(ch)) begin
						ext     = 1'b1;
						mode_n  = M_HEX;
						accum_n = acc_val;
						ovf_n   = acc_ovf;
					end
				end
				M_IDENT: begin
					if (is_alpha_us(ch) || is_digit(ch)) begin
						ext    = 1'b1;
						kw_n   = kw_push(kw_q, ilen_q, ch);
						ilen_n = (ilen_q == 3'd7) ? ilen_q : ilen_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
			if (ext) begin
				cr_n = 1'b0;
			end else begin
				a_v     = (mode_q != M_IDLE);
				mode_n  = M_IDLE;
				accum_n = '0;
				ovf_n   = 1'b0;
				kw_n    = 2'b11;
				ilen_n  = 3'd0;
				cr_n    = 1'b0;
				if ((ch == " ") || (ch == 8'h09)) begin
					// blank: nothing to do
				end else if (ch == 8'h0D) begin
					line_n = line_inc;
					cr_n   = 1'b1;
				end else if (ch == 8'h0A) begin
					if (!cr_q) begin
						line_n = line_inc;
					end
				end else if (ch == "0") begin
					mode_n = M_ZERO;
				end else if (is_digit(ch)) begin
					mode_n  = M_DEC;
					accum_n = VALUE_WIDTH'(ch[3:0]);
				end else if (is_alpha_us(ch)) begin
					mode_n = M_IDENT;
					kw_n   = kw_push(2'b11, 3'd0, ch);
					ilen_n = 3'd1;
				end else begin
					b_v    = 1'b1;
					b_kind = punct_kind(ch);
					b_val  = (b_kind == K_INVALID) ? VALUE_W'(ch) : '0;
				end
			end
		end
	end

	// Pack the tokens from slot 0
	always_comb begin
		res.n  = 2'(a_v) + 2'(b_v);
		res.t0 = a_v ? tok_a : tok_b;
		res.t1 = tok_b;
	end

	// Advance the lexer state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			accum_q <= '0;
			ovf_q   <= 1'b0;
			kw_q    <= 2'b11;
			ilen_q  <= 3'd0;
			line_q  <= LINE_W'(1);
			cr_q    <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_n;
			accum_q <= accum_n;
			ovf_q   <= ovf_n;
			kw_q    <= kw_n;
			ilen_q  <= ilen_n;
			line_q  <= line_n;
			cr_q    <= cr_n;
		end
	end

endmodule

>>> hdl/clex_resq.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two tokens a cycle, hands out one.
module clex_resq (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  clex_pkg::lex_res_t                            push,
	input  logic                                          pop,
	output clex_pkg::tok_t                                head,
	output logic [$clog2(clex_pkg::RES_DEPTH + 1)-1:0]    level
);
	import clex_pkg::*;

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	tok_t             mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_p1;
	logic [CNT_W-1:0] level_q;

	assign wr_p1 = wr_q + PTR_W'(1);
	assign head  = mem_q[rd_q];
	assign level = level_q;

	// Store incoming tokens
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.t0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_p1] <= push.t1;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			level_q <= level_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/c_subset_lexer_core.sv
`timescale 1ns / 1ps
// Top level of the C subset lexer: input register, lexer logic, result queue.
//
//  channel | direction | word contents
//  s_*     | in        | tdata[7:0] ch ; tlast at_end
//  m_*     | out       | tuser[4:0] kind ; tdata value, overflow, line ; tlast last token of a byte
//
// One source byte enters per cycle while s_tready is high and is held in the input register,
// where the lexer logic closes and opens tokens. Its tokens land in a
// four-word result queue when the byte is processed, so the first token shows
// from the queue registers that follow the input register.
// A byte that yields two tokens hands them out as two words. s_tready drops while
// a byte waits in the input register and the queue holds more than two words.
// Reset clears the lexer to idle, line 1.
module c_subset_lexer_core #(
	parameter int VALUE_WIDTH = clex_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] value, [32] overflow, [64:33] line
	output logic [4:0]  m_tuser,   // [4:0] kind
	output logic        m_tlast
);
	import clex_pkg::*;

	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             at_end_s1;
	logic             room, process, pop;
	logic [CNT_W-1:0] level;
	lex_res_t         res, push;
	tok_t             head;

	assign room     = (level <= CNT_W'(RES_DEPTH - 2));
	assign process  = valid_s1 && room;
	assign s_tready = !valid_s1 || process;
	assign pop      = m_tvalid && m_tready;

	// Hold the accepted byte for the lexer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1     <= s_tdata;
			at_end_s1 <= s_tlast;
		end
	end

	clex_scan #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(process),
		.ch     (ch_s1),
		.at_end (at_end_s1),
		.res    (res)
	);

	// Drop the tokens unless the byte is processed this cycle
	always_comb begin
		push   = res;
		if (!process) begin
			push.n = 2'd0;
		end
	end

	clex_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.level (level)
	);

	assign m_tvalid = (level != '0);
	assign m_tdata  = {7'b0000000, head.line, head.overflow, head.value};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

`ifndef ASSERT_OFF
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= CNT_W'(RES_DEPTH))
		else $error("result queue overfilled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == K_EOF)) |-> m_tlast)
		else $error("eof token not marked last");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[64:33] != '0))
		else $error("token carries line zero");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> valid_s1)
		else $error("stalled byte lost");
`endif

endmodule

>>> sim/tb_c_subset_lexer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the C subset lexer: directed table, random source text, token checks.
module tb_c_subset_lexer_core;
	import clex_pkg::*;

	localparam int          ITEMS_TOTAL = 1550;
	localparam int          DIR_ROWS    = 30;
	localparam int          TIMEOUT_NS  = 2_000_000;
	localparam int          ACC_W       = VALUE_WIDTH_DEF;
	localparam logic [63:0] ACC_MAX     = ((64'd1 << (ACC_W - 1)) << 1) - 64'd1;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_ZERO, SCAN_OCT, SCAN_DEC, SCAN_HEXPRE, SCAN_HEX, SCAN_IDENT
	} scan_mode_e;

	// One directed byte; kind, value and line are used only when pin is set
	typedef struct packed {
		logic [7:0]        ch;
		logic              eof;
		logic              pin;
		logic [KIND_W-1:0] kind;
		logic [31:0]       value;
		logic [31:0]       line;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] ch
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;            // [31:0] value, [32] overflow, [64:33] line
	logic [4:0]  m_tuser;            // [4:0] kind
	logic        m_tlast;

	int   err_count   = 0;
	int   items_sent  = 0;
	int   stall_left  = 0;
	logic src_gaps    = 1'b1;
	logic sink_stalls = 1'b1;

	tok_t       tok_expect[$];
	logic [8:0] frag[$];            // {eof, ch} bytes of the source text still to send

	// Lexer mirror
	scan_mode_e  lx_mode;
	logic [63:0] lx_acc;
	logic        lx_ovf;
	logic [1:0]  lx_kw;
	logic [2:0]  lx_len;
	logic [31:0] lx_line;
	logic        lx_cr;
	tok_t        tok_buf[2];
	int          tok_n;

	dir_row_t dir_rows[DIR_ROWS] = '{
		'{"(",    1'b0, 1'b1, K_LPAREN,  32'd0,   32'd1},
		'{8'hFF,  1'b0, 1'b1, K_INVALID, 32'hFF,  32'd1},
		'{8'h00,  1'b0, 1'b1, K_INVALID, 32'd0,   32'd1},
		'{CH_CR,  1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{CH_LF,  1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{CH_LF,  1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"0",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"X",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"=",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"0",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"7",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"9",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"r",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"e",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"t",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"u",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"r",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{"n",    1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{CH_TAB, 1'b0, 1'b0, K_EOF,     32'd0,   32'd0},
		'{8'hA5,  1'b1, 1'b1, K_EOF,     32'd0,   32'd3},
		'{8'h5A,  1'b1, 1'b1, K_EOF,     32'd0,   32'd1}
	};

	c_subset_lexer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("ERROR at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic logic is_word_start(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	task automatic add_token(input logic [KIND_W-1:0] kind, input logic [31:0] value,
		input logic ovf);
		tok_t t;
		t.kind     = kind;
		t.value    = value;
		t.overflow = ovf;
		t.line     = lx_line;
		t.last     = 1'b0;
		tok_buf[tok_n] = t;
		tok_n++;
	endtask

	task automatic clear_token();
		lx_mode = SCAN_IDLE;
		lx_acc  = 64'd0;
		lx_ovf  = 1'b0;
		lx_kw   = 2'b11;
		lx_len  = 3'd0;
	endtask

	task automatic restart_lexer();
		clear_token();
		lx_line = 32'd1;
		lx_cr   = 1'b0;
	endtask

	// Multiply-add one digit, saturate at the accumulator maximum
	task automatic add_digit(input int unsigned base, input int unsigned d);
		logic [63:0] b64;
		logic [63:0] d64;
		b64 = 64'(base);
		d64 = 64'(d);
		if (lx_ovf || (lx_acc > (ACC_MAX - d64) / b64)) begin
			lx_acc = ACC_MAX;
			lx_ovf = 1'b1;
		end else begin
			lx_acc = lx_acc * b64 + d64;
		end
	endtask

	// Drop keyword candidates ruled out by the next identifier character
	task automatic push_ident_char(input logic [7:0] c);
		string int_word = "int";
		string ret_word = "return";
		if ((lx_len >= 3'd3) || (int_word[lx_len] != c)) lx_kw[0] = 1'b0;
		if ((lx_len >= 3'd6) || (ret_word[lx_len] != c)) lx_kw[1] = 1'b0;
		if (lx_len < 3'd7) lx_len++;
	endtask

	// Emit the pending token, if any, and go back to idle
	task automatic close_token();
		case (lx_mode)
			SCAN_ZERO, SCAN_OCT, SCAN_DEC, SCAN_HEX: begin
				add_token(K_NUM, lx_acc[31:0], lx_ovf);
			end
			SCAN_HEXPRE: begin
				add_token(K_BADHEX, 32'd0, 1'b0);
			end
			SCAN_IDENT: begin
				if (lx_kw[0] && (lx_len == 3'd3)) add_token(K_INT, 32'd0, 1'b0);
				else if (lx_kw[1] && (lx_len == 3'd6)) add_token(K_RET, 32'd0, 1'b0);
				else add_token(K_ID, 32'd0, 1'b0);
			end
			default: begin
			end
		endcase
		clear_token();
	endtask

	// Try to extend the pending token with c
	task automatic grow_token(input logic [7:0] c, output logic took);
		int h;
		took = 1'b1;
		h = -1;
		if ((c >= "0") && (c <= "9")) h = int'(c) - int'("0");
		else if ((c >= "a") && (c <= "f")) h = int'(c) - int'("a") + 10;
		else if ((c >= "A") && (c <= "F")) h = int'(c) - int'("A") + 10;
		case (lx_mode)
			SCAN_ZERO: begin
				if ((c == "x") || (c == "X")) begin
					lx_mode = SCAN_HEXPRE;
				end else if ((c >= "0") && (c <= "7")) begin
					lx_mode = SCAN_OCT;
					add_digit(8, 32'(c - "0"));
				end else begin
					took = 1'b0;
				end
			end
			SCAN_OCT: begin
				if ((c >= "0") && (c <= "7")) add_digit(8, 32'(c - "0"));
				else took = 1'b0;
			end
			SCAN_DEC: begin
				if ((c >= "0") && (c <= "9")) add_digit(10, 32'(c - "0"));
				else took = 1'b0;
			end
			SCAN_HEXPRE, SCAN_HEX: begin
				if (h >= 0) begin
					lx_mode = SCAN_HEX;
					add_digit(16, h);
				end else begin
					took = 1'b0;
				end
			end
			SCAN_IDENT: begin
				if (is_word_start(c) || ((c >= "0") && (c <= "9"))) push_ident_char(c);
				else took = 1'b0;
			end
			default: begin
				took = 1'b0;
			end
		endcase
	endtask

	// Handle a byte with no token pending
	task automatic idle_byte(input logic [7:0] c);
		logic              was_cr;
		logic [KIND_W-1:0] k;
		was_cr = lx_cr;
		lx_cr  = 1'b0;
		if ((c == CH_SP) || (c == CH_TAB)) begin
		end else if (c == CH_CR) begin
			if (lx_line != '1) lx_line++;
			lx_cr = 1'b1;
		end else if (c == CH_LF) begin
			if (!was_cr && (lx_line != '1)) lx_line++;
		end else if (c == "0") begin
			lx_mode = SCAN_ZERO;
			lx_acc  = 64'd0;
			lx_ovf  = 1'b0;
		end else if ((c >= "1") && (c <= "9")) begin
			lx_mode = SCAN_DEC;
			lx_acc  = 64'(c - "0");
			lx_ovf  = 1'b0;
		end else if (is_word_start(c)) begin
			lx_mode = SCAN_IDENT;
			lx_kw   = 2'b11;
			lx_len  = 3'd0;
			push_ident_char(c);
		end else begin
			case (c)
				"(":     k = K_LPAREN;
				")":     k = K_RPAREN;
				"{":     k = K_LBRACE;
				"}":     k = K_RBRACE;
				";":     k = K_SEMI;
				"+":     k = K_PLUS;
				"-":     k = K_MINUS;
				"*":     k = K_STAR;
				"/":     k = K_SLASH;
				"%":     k = K_PERCENT;
				"=":     k = K_ASSIGN;
				",":     k = K_COMMA;
				default: k = K_INVALID;
			endcase
			add_token(k, (k == K_INVALID) ? 32'(c) : 32'd0, 1'b0);
		end
	endtask

	// Tokens caused by one accepted byte, into tok_buf
	task automatic lex_step(input logic [7:0] c, input logic eof);
		logic took;
		tok_n = 0;
		if (eof) begin
			close_token();
			add_token(K_EOF, 32'd0, 1'b0);
			restart_lexer();
		end else begin
			grow_token(c, took);
			if (!took) begin
				if (lx_mode != SCAN_IDLE) close_token();
				idle_byte(c);
			end else begin
				lx_cr = 1'b0;
			end
		end
		if (tok_n > 0) tok_buf[tok_n-1].last = 1'b1;
	endtask

	// Offer one word, wait for accept, queue what it must produce
	task automatic send_word(input logic [7:0] ch, input logic eof, input logic pin,
		input tok_t pinned);
		int k;
		if (src_gaps && ($urandom_range(0, 4) == 0)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		lex_step(ch, eof);
		if (pin) begin
			tok_expect.insert(tok_expect.size(), pinned);
		end else begin
			for (k = 0; k < tok_n; k++) tok_expect.insert(tok_expect.size(), tok_buf[k]);
		end
		items_sent++;
	endtask

	task automatic push_ch(input logic [7:0] c);
		frag.insert(frag.size(), {1'b0, c});
	endtask

	// Append one piece of source text: mostly well-formed tokens, some noise
	task automatic build_fragment();
		string punct = "(){};+-*/%=,";
		string hexd  = "0123456789abcdefABCDEF";
		string idch  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		string words[12] = '{"int", "return", "in", "retur", "integer", "returns",
			"i", "r", "intx", "return_", "Int", "ret"};
		string w;
		int    pick;
		int    n;
		int    k;
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			// decimal, now and then long enough to saturate
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
			push_ch(8'("1" + $urandom_range(0, 8)));
			for (k = 0; k < n; k++) push_ch(8'("0" + $urandom_range(0, 9)));
		end else if (pick < 26) begin
			// octal, with a stray 8 or 9 sometimes
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 4);
			push_ch("0");
			for (k = 0; k < n; k++) begin
				push_ch(8'("0" + (($urandom_range(0, 9) == 0) ? $urandom_range(8, 9)
					: $urandom_range(0, 7))));
			end
		end else if (pick < 36) begin
			// hex, bare prefix included
			if ($urandom_range(0, 4) == 0) n = 0;
			else if ($urandom_range(0, 7) == 0) n = $urandom_range(8, 11);
			else n = $urandom_range(1, 4);
			push_ch("0");
			push_ch($urandom_range(0, 1) ? "x" : "X");
			for (k = 0; k < n; k++) push_ch(hexd[$urandom_range(0, 21)]);
		end else if (pick < 52) begin
			// identifiers, keywords and near misses
			if ($urandom_range(0, 2) == 0) begin
				w = words[$urandom_range(0, 11)];
				for (k = 0; k < w.len(); k++) push_ch(w[k]);
			end else begin
				n = $urandom_range(1, 9);
				push_ch(idch[$urandom_range(0, 52)]);
				for (k = 1; k < n; k++) push_ch(idch[$urandom_range(0, 62)]);
			end
		end else if (pick < 72) begin
			push_ch(punct[$urandom_range(0, 11)]);
		end else if (pick < 88) begin
			case ($urandom_range(0, 5))
				0: push_ch(CH_SP);
				1: push_ch(CH_TAB);
				2: push_ch(CH_CR);
				3: push_ch(CH_LF);
				4: begin
					push_ch(CH_CR);
					push_ch(CH_LF);
				end
				default: begin
					push_ch(CH_LF);
					push_ch(CH_CR);
				end
			endcase
		end else if (pick < 97) begin
			push_ch(8'($urandom_range(0, 255)));
		end else begin
			frag.insert(frag.size(), {1'b1, 8'($urandom_range(0, 255))});
		end
		if ($urandom_range(0, 1) == 0) push_ch($urandom_range(0, 1) ? CH_SP : CH_LF);
	endtask

	task automatic run_random(input int upto);
		logic [8:0] w;
		while (items_sent < upto) begin
			if (frag.size() == 0) build_fragment();
			w = frag.pop_front();
			send_word(w[7:0], w[8], 1'b0, '0);
		end
	endtask

	// Hold the source until every queued token has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tok_expect.size() != 0) @(posedge clk);
	endtask

	// Result side: accept with random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stalls && ($urandom_range(0, 4) == 0)) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted token with the oldest expected one
	always @(posedge clk) begin : check_tokens
		tok_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (tok_expect.size() == 0) begin
				report_mismatch("unexpected token, kind", 32'(m_tuser), 32'd0);
			end else begin
				want = tok_expect.pop_front();
				if (m_tuser != want.kind)
					report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
				if (m_tdata[31:0] != want.value)
					report_mismatch("value", m_tdata[31:0], want.value);
				if (m_tdata[32] != want.overflow)
					report_mismatch("overflow", 32'(m_tdata[32]), 32'(want.overflow));
				if (m_tdata[64:33] != want.line)
					report_mismatch("line", m_tdata[64:33], want.line);
				if (m_tlast != want.last)
					report_mismatch("last", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	initial begin : stimulus
		int       r;
		dir_row_t row;
		tok_t     pinned;
		restart_lexer();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (r = 0; r < DIR_ROWS; r++) begin
			row             = dir_rows[r];
			pinned.kind     = row.kind;
			pinned.value    = row.value;
			pinned.overflow = 1'b0;
			pinned.line     = row.line;
			pinned.last     = 1'b1;
			send_word(row.ch, row.eof, row.pin, pinned);
		end
		drain_results();

		// Random source text, idling switched per stretch
		run_random(700);
		drain_results();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		run_random(1000);
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		run_random(1250);
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		run_random(ITEMS_TOTAL);

		// Let the last tokens out
		s_tvalid <= 1'b0;
		while (tok_expect.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
